### design/lru_page_replacement_unit_macros.svh
// ----------------------------------------------------------------------------
// lru page replacement unit assertion macros
// shared concurrent assertion forms, clocked on clk and reset by arst_n
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// condition holds whenever the antecedent holds
`define LPR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the antecedent
`define LPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// shared types and constants of the lru page replacement unit
// ----------------------------------------------------------------------------
package lpr_pkg;

	localparam int unsigned CFG_W   = 4;
	localparam int unsigned CNT_W   = 32;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	// per-cell control from the top level
	typedef struct packed {
		logic load;
		logic valid;
		logic top;
		logic evict;
	} lpr_cell_ctl_t;

endpackage

### design/lpr_cell.sv
// ----------------------------------------------------------------------------
// lpr_cell
// one recency slot: holds a page, compares it and takes its newer neighbor
// ----------------------------------------------------------------------------
module lpr_cell import lpr_pkg::*; #(
	parameter int unsigned PAGE_BITS = 16
) (
	input  logic                 clk,
	input  logic [PAGE_BITS-1:0] ref_page,
	input  logic [PAGE_BITS-1:0] up_page,
	input  logic                 shift_in,
	input  lpr_cell_ctl_t        ctl,
	output logic [PAGE_BITS-1:0] page,
	output logic                 match,
	output logic                 shift_out
);

	logic [PAGE_BITS-1:0] page_q;

	assign match     = ctl.valid && (page_q == ref_page);
	assign shift_out = shift_in || match;
	assign page      = page_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (ctl.top) begin
				page_q <= ref_page;
			end else if (ctl.valid && (shift_out || ctl.evict)) begin
				page_q <= up_page;
			end
		end
	end

endmodule

### design/lpr_sat_cnt.sv
// ----------------------------------------------------------------------------
// lpr_sat_cnt
// saturating running total with synchronous clear
// ----------------------------------------------------------------------------
module lpr_sat_cnt import lpr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             inc,
	output logic [CNT_W-1:0] count
);

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] base;

	assign base  = clr ? '0 : cnt_q;
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clr || inc) begin
			if (inc && (base != '1)) begin
				cnt_q <= base + CNT_W'(1);
			end else begin
				cnt_q <= base;
			end
		end
	end

endmodule

### design/lru_page_replacement_unit.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// lru page replacement over a chain of recency cells
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries page_number and first_of_run;
//   first_of_run clears the resident list and both totals before its page
//   output channel out_valid/out_ready carries is_fault, fault_total, hit_total
//   config channel cfg_valid/cfg_ready writes frames_in_use (cfg_data), always
//   ready; 0 counts as one frame, values above FRAMES as FRAMES
// latency: a result is valid the cycle after its input transfer
// throughput: one reference per cycle while results are taken; all cells compare
//   in parallel and the hit position ripples along the cell chain within that cycle
// reset: list empty, totals zero, frames_in_use 8
// stall: while out_ready is low a held result blocks the input; a new item is
//   still taken in the same cycle the held result transfers
// ----------------------------------------------------------------------------
`include "lru_page_replacement_unit_macros.svh"

module lru_page_replacement_unit import lpr_pkg::*; #(
	parameter int unsigned FRAMES    = 8,
	parameter int unsigned PAGE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PAGE_BITS-1:0] page_number,
	input  logic                 first_of_run,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 is_fault,
	output logic [CNT_W-1:0]     fault_total,
	output logic [CNT_W-1:0]     hit_total
);

	localparam int unsigned FCW = $clog2(FRAMES + 1);

	logic [CFG_W-1:0]     frames_cfg_q;
	logic [FCW-1:0]       filled_q;
	logic                 out_valid_q;
	logic                 is_fault_q;

	logic                 accept;
	logic [FCW-1:0]       cap;
	logic [FCW-1:0]       filled_eff;
	logic                 hit;
	logic                 has_room;
	logic                 evict;
	logic [FCW-1:0]       top_idx;
	logic [FRAMES:0]      shift;
	logic [FRAMES-1:0]    match_v;
	logic [PAGE_BITS-1:0] page_v [FRAMES];
	lpr_cell_ctl_t        ctl_v  [FRAMES];

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign is_fault  = is_fault_q;

	always_comb begin
		if (frames_cfg_q == '0) begin
			cap = FCW'(1);
		end else if (8'(frames_cfg_q) > 8'(FRAMES)) begin
			cap = FCW'(FRAMES);
		end else begin
			cap = FCW'(frames_cfg_q);
		end
	end

	assign filled_eff = first_of_run ? '0 : filled_q;
	assign hit        = shift[FRAMES];
	assign has_room   = filled_eff < cap;
	assign evict      = !hit && !has_room && (filled_eff != '0);
	assign top_idx    = (hit || !has_room) ? filled_eff - FCW'(1) : filled_eff;
	assign shift[0]   = 1'b0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		assign ctl_v[i].load  = accept;
		assign ctl_v[i].valid = FCW'(i) < filled_eff;
		assign ctl_v[i].top   = FCW'(i) == top_idx;
		assign ctl_v[i].evict = evict;

		lpr_cell #(
			.PAGE_BITS(PAGE_BITS)
		) u_cell (
			.clk      (clk),
			.ref_page (page_number),
			.up_page  ((i + 1 < FRAMES) ? page_v[(i + 1) % FRAMES] : page_number),
			.shift_in (shift[i]),
			.ctl      (ctl_v[i]),
			.page     (page_v[i]),
			.match    (match_v[i]),
			.shift_out(shift[i+1])
		);
	end

	lpr_sat_cnt u_fault_cnt (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (accept && first_of_run),
		.inc   (accept && !hit),
		.count (fault_total)
	);

	lpr_sat_cnt u_hit_cnt (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (accept && first_of_run),
		.inc   (accept && hit),
		.count (hit_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frames_cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				filled_q    <= (!hit && has_room) ? filled_eff + FCW'(1) : filled_eff;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_fault_q <= !hit;
		end
	end

	`LPR_ASSERT_SAME(a_match_unique, accept, $onehot0(match_v), "page resident in two frames")
	`LPR_ASSERT_NEXT(a_append_grows, accept && !hit && has_room,
		filled_q == $past(filled_eff) + FCW'(1), "fill count did not grow on append")
	`LPR_ASSERT_NEXT(a_hit_result, accept && hit, out_valid && !is_fault,
		"hit not reported")
	`LPR_ASSERT_NEXT(a_run_start, accept && first_of_run,
		is_fault && (fault_total == CNT_W'(1)) && (hit_total == '0),
		"run start did not clear totals")
	`LPR_ASSERT_SAME(a_fill_bound, 1'b1, filled_q <= FCW'(FRAMES), "fill count beyond frames")

endmodule

### tb/lru_page_replacement_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_page_replacement_checker
// watches the config, reference and result channels of the lru page
// replacement unit, keeps its own recency list, frame setting and totals,
// predicts one result per reference transfer and compares every result
// transfer field by field against the oldest prediction
// ----------------------------------------------------------------------------
module lru_page_replacement_checker import lpr_pkg::*; #(
	parameter int unsigned FRAMES    = 8,
	parameter int unsigned PAGE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [PAGE_BITS-1:0] page_number,
	input  logic                 first_of_run,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 is_fault,
	input  logic [CNT_W-1:0]     fault_total,
	input  logic [CNT_W-1:0]     hit_total,
	output int                   failures,
	output int                   pending
);

	typedef struct packed {
		logic             is_fault;
		logic [CNT_W-1:0] faults;
		logic [CNT_W-1:0] hits;
	} ref_outcome_t;

	ref_outcome_t         expected_outcomes [$];
	logic [PAGE_BITS-1:0] resident [FRAMES];
	int unsigned          resident_count;
	logic [CNT_W-1:0]     fault_count;
	logic [CNT_W-1:0]     hit_count;
	logic [CFG_W-1:0]     frames_setting;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	task automatic predict_reference(input logic [PAGE_BITS-1:0] pg, input logic clear_first);
		int unsigned  cap;
		int unsigned  pos;
		bit           found;
		ref_outcome_t r;
		if (clear_first) begin
			resident_count = 0;
			fault_count = '0;
			hit_count = '0;
		end
		cap = frames_setting;
		if (cap == 0)
			cap = 1;
		if (cap > FRAMES)
			cap = FRAMES;
		found = 1'b0;
		pos = 0;
		for (int unsigned i = 0; i < resident_count; i++) begin
			if (!found && resident[i] == pg) begin
				found = 1'b1;
				pos = i;
			end
		end
		// hit moves the page to the newest end; a fault on a full list drops the oldest
		if (found || resident_count >= cap) begin
			for (int unsigned i = pos; i + 1 < resident_count; i++)
				resident[i] = resident[i + 1];
			resident[resident_count - 1] = pg;
		end else begin
			resident[resident_count] = pg;
			resident_count++;
		end
		if (found)
			hit_count = bump(hit_count);
		else
			fault_count = bump(fault_count);
		r.is_fault = !found;
		r.faults = fault_count;
		r.hits = hit_count;
		expected_outcomes.insert(expected_outcomes.size(), r);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		ref_outcome_t want;
		if (!arst_n) begin
			expected_outcomes.delete();
			resident_count = 0;
			fault_count = '0;
			hit_count = '0;
			frames_setting = CFG_RESET;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_outcomes.size() == 0) begin
					$display("%0t: unexpected result transfer, is_fault %0b fault_total %0d hit_total %0d",
						$time, is_fault, fault_total, hit_total);
					failures++;
				end else begin
					want = expected_outcomes.pop_front();
					if (is_fault !== want.is_fault) begin
						$display("%0t: is_fault mismatch, expected %0b actual %0b",
							$time, want.is_fault, is_fault);
						failures++;
					end
					if (fault_total !== want.faults) begin
						$display("%0t: fault_total mismatch, expected %0d actual %0d",
							$time, want.faults, fault_total);
						failures++;
					end
					if (hit_total !== want.hits) begin
						$display("%0t: hit_total mismatch, expected %0d actual %0d",
							$time, want.hits, hit_total);
						failures++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				frames_setting = cfg_data;
			if (in_valid && in_ready)
				predict_reference(page_number, first_of_run);
			pending = expected_outcomes.size();
		end
	end

endmodule

### tb/tb_lru_page_replacement_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement_unit
// a short directed run on the reset frame setting, then phases of random
// references drawn mostly from a small working set so that hits, evictions
// and refills happen at every list position; each phase writes a new frame
// setting while the unit is idle, zero and out-of-range values included;
// random idling on both channels and one long result stall
// ----------------------------------------------------------------------------
module tb_lru_page_replacement_unit;
	import lpr_pkg::*;

	localparam int unsigned FRAMES    = 8;
	localparam int unsigned PAGE_BITS = 16;
	localparam int TOTAL_REFS      = 1550;
	localparam int TAIL_REFS       = 150;
	localparam int PRESSURE_AT     = 500;
	localparam int PRESSURE_CYCLES = 60;
	localparam int STALL_LIMIT     = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [PAGE_BITS-1:0] page_number;
	logic                 first_of_run;
	logic                 out_valid;
	logic                 out_ready;
	logic                 is_fault;
	logic [CNT_W-1:0]     fault_total;
	logic [CNT_W-1:0]     hit_total;

	int failures;
	int pending;
	int sent_count;
	int stall_cycles;
	bit pressure_on;
	bit pressure_done;

	lru_page_replacement_unit #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page_number  (page_number),
		.first_of_run (first_of_run),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_fault     (is_fault),
		.fault_total  (fault_total),
		.hit_total    (hit_total)
	);

	lru_page_replacement_checker #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page_number  (page_number),
		.first_of_run (first_of_run),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_fault     (is_fault),
		.fault_total  (fault_total),
		.hit_total    (hit_total),
		.failures     (failures),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic send_ref(input logic [PAGE_BITS-1:0] pg, input logic clear_first);
		logic taken;
		in_valid <= 1'b1;
		page_number <= pg;
		first_of_run <= clear_first;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end
		sent_count++;
		if (!pressure_on && sent_count < TOTAL_REFS - TAIL_REFS && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] setting);
		logic taken;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= setting;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : receiver
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (sent_count >= TOTAL_REFS - TAIL_REFS) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if (!pressure_done && sent_count >= PRESSURE_AT && in_valid) begin
				pressure_on = 1'b1;
				out_ready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
				pressure_on = 1'b0;
				pressure_done = 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [PAGE_BITS-1:0] pool [12];
		logic [CFG_W-1:0]     frame_plan [6];
		logic [PAGE_BITS-1:0] dir_pages [17];
		logic [16:0]          dir_first;
		logic                 clear_first;
		int                   ws;
		int                   phase;
		int                   phase_len;
		int                   pick;
		frame_plan = '{4'd1, 4'd0, 4'd15, 4'd2, 4'd9, 4'd8};
		dir_pages = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h0003,
			16'h0004, 16'h0005, 16'h0006, 16'h8000, 16'hFFFF, 16'h0002, 16'h5555,
			16'hAAAA, 16'h0002, 16'h0001, 16'h0002};
		dir_first = 17'h10001;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		page_number = '0;
		first_of_run = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset frame setting: fill, hit, evict, refill, clear with a resident page
		for (int i = 0; i < 17; i++)
			send_ref(dir_pages[i], dir_first[i]);

		phase = 0;
		while (sent_count < TOTAL_REFS) begin
			in_valid <= 1'b0;
			write_frames(phase < 6 ? frame_plan[phase] : CFG_W'($urandom_range(0, 15)));
			ws = (phase == 2) ? 12 : $urandom_range(1, 12);
			foreach (pool[k])
				pool[k] = PAGE_BITS'($urandom_range(0, 16'hFFFF));
			phase_len = $urandom_range(100, 200);
			for (int n = 0; n < phase_len && sent_count < TOTAL_REFS; n++) begin
				pick = $urandom_range(0, 99);
				// keep the full list across the drop to two frames
				if (n == 0)
					clear_first = (phase == 3) ? 1'b0 : 1'($urandom_range(0, 1));
				else
					clear_first = (pick < 3);
				if (pick >= 3 && pick < 13)
					send_ref(PAGE_BITS'($urandom_range(0, 16'hFFFF)), clear_first);
				else
					send_ref(pool[$urandom_range(0, ws - 1)], clear_first);
			end
			phase++;
		end
		in_valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### lru_page_replacement_unit.f
+incdir+design
design/lpr_pkg.sv
design/lpr_cell.sv
design/lpr_sat_cnt.sv
design/lru_page_replacement_unit.sv
tb/lru_page_replacement_checker.sv
tb/tb_lru_page_replacement_unit.sv
